// ----- rtl/core/frvd_pkg.sv -----
// ----------------------------------------------------------------------------
// frvd_pkg
// Shared types and constants of the frame rms voice detector.
// ----------------------------------------------------------------------------
package frvd_pkg;

    // configuration register indexes
    localparam logic [7:0] REG_RMS_THRESHOLD  = 8'd0;
    localparam logic [7:0] REG_CONFIRM_FRAMES = 8'd1;

    localparam logic [15:0] RMS_THRESHOLD_RESET  = 16'd2500;
    localparam logic [7:0]  CONFIRM_FRAMES_RESET = 8'd3;
    localparam logic [7:0]  LOUD_RUN_MAX         = 8'd255;

    // square root: 16 result bits, one per step
    localparam int SQRT_STEPS = 16;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DIV,
        ST_SQRT_LOAD,
        ST_SQRT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic sqrt_load;
        logic sqrt_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

// ----- rtl/core/frvd_ctrl.sv -----
// ----------------------------------------------------------------------------
// frvd_ctrl
// Sequencer: accumulate, divide by sample count, square root, result.
// ----------------------------------------------------------------------------
module frvd_ctrl #(
    parameter int SUM_W = 41
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    input  frvd_pkg::status_t status,
    output frvd_pkg::cmd_t    cmd
);

    localparam int STEP_W = $clog2(SUM_W);

    frvd_pkg::state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= frvd_pkg::ST_ACCUM;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            frvd_pkg::ST_ACCUM: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    state_next = frvd_pkg::ST_DIV;
                    step_next  = '0;
                end
            end
            frvd_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    state_next = frvd_pkg::ST_SQRT_LOAD;
                end
            end
            frvd_pkg::ST_SQRT_LOAD: begin
                cmd.sqrt_load = 1'b1;
                step_next     = '0;
                state_next    = frvd_pkg::ST_SQRT;
            end
            frvd_pkg::ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_W'(frvd_pkg::SQRT_STEPS - 1)) begin
                    state_next = frvd_pkg::ST_FINISH;
                end
            end
            frvd_pkg::ST_FINISH: begin
                // wait for a free output slot
                if (!status.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = frvd_pkg::ST_ACCUM;
                end
            end
            default: begin
                state_next = frvd_pkg::ST_ACCUM;
            end
        endcase
    end

endmodule

// ----- rtl/core/frvd_datapath.sv -----
// ----------------------------------------------------------------------------
// frvd_datapath
// Square accumulator, restoring divider, digit square root, run counter
// and output register.
// ----------------------------------------------------------------------------
module frvd_datapath #(
    parameter int MAX_FRAME_SAMPLES = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  frvd_pkg::cmd_t     cmd,
    output frvd_pkg::status_t  status,
    input  logic signed [31:0] s_tdata,
    input  logic               cfg_valid,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,
    output logic [1:0]         m_tuser
);

    localparam int SUM_W = 31 + $clog2(MAX_FRAME_SAMPLES);
    localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);

    logic [15:0]      thresh_reg;
    logic [7:0]       confirm_reg;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [31:0]      rad_reg, rad_next;
    logic [17:0]      srem_reg, srem_next;
    logic [15:0]      root_reg, root_next;
    logic [7:0]       run_reg, run_next;
    logic             out_valid_reg, out_valid_next;
    logic [15:0]      out_rms_reg;
    logic             out_loud_reg, out_speech_reg;

    logic signed [15:0] hi;
    logic [15:0]        mag;
    logic [31:0]        sq;
    logic [CNT_W:0]     rem_shift;
    logic               div_ge;
    logic [19:0]        srem_shift, trial;
    logic               sqrt_ge;
    logic               loud, speech;
    logic [7:0]         run_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg  <= frvd_pkg::RMS_THRESHOLD_RESET;
            confirm_reg <= frvd_pkg::CONFIRM_FRAMES_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == frvd_pkg::REG_RMS_THRESHOLD) begin
                thresh_reg <= cfg_data;
            end else if (cfg_index == frvd_pkg::REG_CONFIRM_FRAMES) begin
                confirm_reg <= cfg_data[7:0];
            end
        end
    end

    // sample magnitude and its square
    assign hi  = s_tdata[31:16];
    assign mag = hi[15] ? 16'(-hi) : hi;
    assign sq  = mag * mag;

    // restoring divide, quotient bits shift into the sum register
    assign rem_shift = {rem_reg, sum_reg[SUM_W-1]};
    assign div_ge    = rem_shift >= {1'b0, count_reg};

    // two radicand bits per root bit
    assign srem_shift = {srem_reg, rad_reg[31:30]};
    assign trial      = {2'b00, root_reg, 2'b01};
    assign sqrt_ge    = srem_shift >= trial;

    assign loud    = root_reg >= thresh_reg;
    assign run_inc = (run_reg < frvd_pkg::LOUD_RUN_MAX) ? run_reg + 8'd1 : run_reg;
    assign speech  = loud && (run_inc >= confirm_reg);

    always_comb begin
        sum_next       = sum_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        rad_next       = rad_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        run_next       = run_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (cmd.accept) begin
            rem_next = '0;
            // samples past a full frame are dropped
            if (count_reg < CNT_W'(MAX_FRAME_SAMPLES)) begin
                sum_next   = sum_reg + SUM_W'(sq);
                count_next = count_reg + 1'b1;
            end
        end
        if (cmd.div_step) begin
            sum_next = {sum_reg[SUM_W-2:0], div_ge};
            rem_next = div_ge ? CNT_W'(rem_shift - {1'b0, count_reg})
                              : rem_shift[CNT_W-1:0];
        end
        if (cmd.sqrt_load) begin
            // mean never exceeds 2^30
            rad_next  = {1'b0, sum_reg[30:0]};
            srem_next = '0;
            root_next = '0;
        end
        if (cmd.sqrt_step) begin
            rad_next  = {rad_reg[29:0], 2'b00};
            srem_next = sqrt_ge ? 18'(srem_shift - trial) : 18'(srem_shift);
            root_next = {root_reg[14:0], sqrt_ge};
        end
        if (cmd.finish) begin
            sum_next       = '0;
            count_next     = '0;
            run_next       = (loud && !speech) ? run_inc : 8'd0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            count_reg     <= '0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        rad_reg  <= rad_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        if (cmd.finish) begin
            out_rms_reg    <= root_reg;
            out_loud_reg   <= loud;
            out_speech_reg <= speech;
        end
    end

    assign status.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_rms_reg;
    assign m_tuser         = {out_speech_reg, out_loud_reg};

endmodule

// ----- rtl/core/frame_rms_voice_detector.sv -----
// ----------------------------------------------------------------------------
// frame_rms_voice_detector
// Frame energy voice activity detector with exact integer rms.
// ----------------------------------------------------------------------------
// Each input beat is accepted while the block is in its accumulate state;
// the signed top half of the word is squared and summed, up to
// MAX_FRAME_SAMPLES per frame. On the beat with tlast the block stops taking
// input while the bit-serial divider runs, the square root is loaded and run,
// and the result is posted (held back while the previous result is still
// waiting on m_tready). One result beat per frame: rms, loud flag and speech
// flag.
module frame_rms_voice_detector #(
    parameter int MAX_FRAME_SAMPLES = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic signed [31:0] s_tdata,   // [31:0] sample_word
    input  logic               s_tlast,   // frame_end
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,   // [15:0] rms_value
    output logic [1:0]         m_tuser,   // [0] frame_loud, [1] speech_detected
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int SUM_W = 31 + $clog2(MAX_FRAME_SAMPLES);

    frvd_pkg::cmd_t    cmd;
    frvd_pkg::status_t status;

    assign cfg_ready = 1'b1;

    frvd_ctrl #(
        .SUM_W (SUM_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    frvd_datapath #(
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
